// ===== rtl/lzss_window_decoder_assert.svh =====
// Assertion macros used by the checker file of the window decoder.
// Each macro expects signals named clk and arst_n in the scope where it is used.
`ifndef LZSS_WINDOW_DECODER_ASSERT_SVH
`define LZSS_WINDOW_DECODER_ASSERT_SVH

// Same-cycle implication.
`define LZWD_ASSERT_IMPL(lbl, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error(msg);

// Next-cycle implication.
`define LZWD_ASSERT_NEXT(lbl, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error(msg);

`endif

// ===== rtl/lzwd_pkg.sv =====
`timescale 1ns / 1ps

package lzwd_pkg;

	localparam int WIN_SIZE  = 8192;
	localparam int LA_SIZE   = 60;
	localparam int MIN_MATCH = 2;
	localparam int WIN_AW    = $clog2(WIN_SIZE);
	localparam int LEN_W     = $clog2(LA_SIZE + 1);
	localparam int LCODE_W   = 6;
	localparam int SUM_W     = LCODE_W + 1;
	localparam int QDEPTH    = 2;
	localparam int QPTR_W    = $clog2(QDEPTH);
	localparam int QCNT_W    = $clog2(QDEPTH + 1);

	localparam logic [7:0] SPACE_BYTE = 8'h20;
	localparam logic [WIN_AW-1:0] FILL_START = WIN_AW'(WIN_SIZE - LA_SIZE);

	localparam logic [1:0] CMD_LITERAL = 2'd0;
	localparam logic [1:0] CMD_COPY    = 2'd1;
	localparam logic [1:0] CMD_END     = 2'd2;

	typedef enum logic [1:0] {
		OP_LIT  = 2'd0,
		OP_COPY = 2'd1,
		OP_END  = 2'd2
	} op_t;

	typedef struct packed {
		op_t               op;
		logic [7:0]        lit;
		logic [LEN_W-1:0]  len;
		logic [WIN_AW-1:0] src;
		logic [WIN_AW-1:0] dst;
	} entry_t;

endpackage

// ===== rtl/lzwd_queue.sv =====
`timescale 1ns / 1ps

module lzwd_queue (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push_valid,
	output logic             push_ready,
	input  lzwd_pkg::entry_t push_entry,
	output logic             pop_valid,
	input  logic             pop_ready,
	output lzwd_pkg::entry_t pop_entry
);

	lzwd_pkg::entry_t                 slot_q [lzwd_pkg::QDEPTH];
	logic [lzwd_pkg::QPTR_W-1:0]      wr_ptr_q;
	logic [lzwd_pkg::QPTR_W-1:0]      rd_ptr_q;
	logic [lzwd_pkg::QCNT_W-1:0]      count_q;
	logic                             do_push;
	logic                             do_pop;

	assign push_ready = count_q != lzwd_pkg::QCNT_W'(lzwd_pkg::QDEPTH);
	assign pop_valid  = count_q != '0;
	assign pop_entry  = slot_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == lzwd_pkg::QPTR_W'(lzwd_pkg::QDEPTH - 1)) ?
					'0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == lzwd_pkg::QPTR_W'(lzwd_pkg::QDEPTH - 1)) ?
					'0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ===== rtl/lzwd_front.sv =====
`timescale 1ns / 1ps

module lzwd_front (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [1:0]                    command,
	input  logic [7:0]                    literal_byte,
	input  logic [lzwd_pkg::LCODE_W-1:0]  length_code,
	input  logic [lzwd_pkg::WIN_AW-1:0]   distance,
	input  logic                          init_busy,
	output logic                          push_valid,
	input  logic                          push_ready,
	output lzwd_pkg::entry_t              push_entry
);

	// The front keeps its own copy of the write pointer, advanced by the length of every
	// literal or copy it classifies and cleared by an end, so copy addresses are fixed at accept time.
	logic [lzwd_pkg::WIN_AW-1:0] wp_q;
	logic [lzwd_pkg::WIN_AW-1:0] wp_next;
	logic [lzwd_pkg::SUM_W-1:0]  len_sum;
	logic [lzwd_pkg::LEN_W-1:0]  len_sat;
	logic                        accept;

	assign in_ready = !init_busy && push_ready;
	assign accept   = in_valid && in_ready;
	assign len_sum  = {1'b0, length_code} + lzwd_pkg::SUM_W'(lzwd_pkg::MIN_MATCH);
	assign len_sat  = (len_sum > lzwd_pkg::SUM_W'(lzwd_pkg::LA_SIZE)) ?
		lzwd_pkg::LEN_W'(lzwd_pkg::LA_SIZE) : lzwd_pkg::LEN_W'(len_sum);

	always_comb begin
		push_entry.op  = lzwd_pkg::OP_LIT;
		push_entry.lit = literal_byte;
		push_entry.len = len_sat;
		push_entry.src = wp_q - distance - 1'b1;
		push_entry.dst = wp_q;
		push_valid     = 1'b0;
		wp_next        = wp_q;
		unique case (command)
			lzwd_pkg::CMD_LITERAL: begin
				push_valid = in_valid && !init_busy;
				wp_next    = wp_q + 1'b1;
			end
			lzwd_pkg::CMD_COPY: begin
				push_entry.op = lzwd_pkg::OP_COPY;
				push_valid    = in_valid && !init_busy;
				wp_next       = wp_q + lzwd_pkg::WIN_AW'(len_sat);
			end
			lzwd_pkg::CMD_END: begin
				push_entry.op = lzwd_pkg::OP_END;
				push_valid    = in_valid && !init_busy;
				wp_next       = '0;
			end
			default: begin
				// The unused command code is taken and dropped.
				push_valid = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
		end else if (accept) begin
			wp_q <= wp_next;
		end
	end

endmodule

// ===== rtl/lzwd_back.sv =====
`timescale 1ns / 1ps

module lzwd_back (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             q_valid,
	output logic             q_ready,
	input  lzwd_pkg::entry_t q_entry,
	output logic             out_valid,
	input  logic             out_ready,
	output logic [7:0]       out_byte,
	output logic             last,
	output logic             init_busy
);

	typedef enum logic [3:0] {
		ST_INIT = 4'b0001,
		ST_IDLE = 4'b0010,
		ST_COPY = 4'b0100,
		ST_FILL = 4'b1000
	} state_t;

	state_t                      state_q;
	logic [7:0]                  mem_q [lzwd_pkg::WIN_SIZE];
	logic [lzwd_pkg::WIN_AW-1:0] sweep_q;
	logic [lzwd_pkg::WIN_AW-1:0] rd_addr_q;
	logic [lzwd_pkg::WIN_AW-1:0] wr_addr_q;
	logic [lzwd_pkg::LEN_W-1:0]  remain_q;

	logic                        s2_valid_s2;
	logic                        s2_lit_s2;
	logic [7:0]                  s2_data_s2;
	logic                        s2_last_s2;
	logic [lzwd_pkg::WIN_AW-1:0] s2_waddr_s2;
	logic [7:0]                  rd_data_s2;
	logic                        byp_s2;
	logic [7:0]                  byp_data_s2;

	logic                        out_valid_q;
	logic [7:0]                  out_byte_q;
	logic                        last_q;

	logic                        s2_done;
	logic                        adv;
	logic                        sweeping;
	logic                        take_lit;
	logic                        rd_en;
	logic [7:0]                  s2_byte;
	logic                        mem_we;
	logic [lzwd_pkg::WIN_AW-1:0] mem_waddr;
	logic [7:0]                  mem_wdata;
	logic [7:0]                  fill_byte;

	assign s2_done   = s2_valid_s2 && (!out_valid_q || out_ready);
	assign adv       = !s2_valid_s2 || s2_done;
	assign sweeping  = (state_q == ST_INIT) || (state_q == ST_FILL);
	assign init_busy = state_q == ST_INIT;
	assign s2_byte   = s2_lit_s2 ? s2_data_s2 : (byp_s2 ? byp_data_s2 : rd_data_s2);
	assign fill_byte = (sweep_q >= lzwd_pkg::FILL_START) ? lzwd_pkg::SPACE_BYTE : 8'h00;
	assign mem_we    = sweeping || s2_done;
	assign mem_waddr = sweeping ? sweep_q : s2_waddr_s2;
	assign mem_wdata = sweeping ? fill_byte : s2_byte;

	always_comb begin
		q_ready  = 1'b0;
		take_lit = 1'b0;
		rd_en    = 1'b0;
		if (state_q == ST_IDLE && q_valid) begin
			unique case (q_entry.op)
				lzwd_pkg::OP_LIT: begin
					q_ready  = adv;
					take_lit = adv;
				end
				lzwd_pkg::OP_COPY: q_ready = 1'b1;
				// The refill shares the write port, so stage 2 must drain first.
				lzwd_pkg::OP_END:  q_ready = !s2_valid_s2;
				default:           q_ready = 1'b1;
			endcase
		end
		if (state_q == ST_COPY && adv) begin
			rd_en = 1'b1;
		end
	end

	// A read that meets a write to the same address in one cycle takes the new
	// byte; this is how an overlapping copy repeats what it just wrote.
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem_q[mem_waddr] <= mem_wdata;
		end
		if (rd_en) begin
			rd_data_s2  <= mem_q[rd_addr_q];
			byp_s2      <= mem_we && (mem_waddr == rd_addr_q);
			byp_data_s2 <= mem_wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (take_lit) begin
			s2_lit_s2   <= 1'b1;
			s2_data_s2  <= q_entry.lit;
			s2_last_s2  <= 1'b1;
			s2_waddr_s2 <= q_entry.dst;
		end else if (rd_en) begin
			s2_lit_s2   <= 1'b0;
			s2_last_s2  <= remain_q == lzwd_pkg::LEN_W'(1);
			s2_waddr_s2 <= wr_addr_q;
		end
		if (s2_done) begin
			out_byte_q <= s2_byte;
			last_q     <= s2_last_s2;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_INIT;
			sweep_q     <= '0;
			rd_addr_q   <= '0;
			wr_addr_q   <= '0;
			remain_q    <= '0;
			s2_valid_s2 <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (take_lit || rd_en) begin
				s2_valid_s2 <= 1'b1;
			end else if (s2_done) begin
				s2_valid_s2 <= 1'b0;
			end

			if (s2_done) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end

			unique case (state_q)
				ST_INIT, ST_FILL: begin
					sweep_q <= sweep_q + 1'b1;
					if (sweep_q == '1) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (q_valid && q_ready && q_entry.op == lzwd_pkg::OP_COPY) begin
						rd_addr_q <= q_entry.src;
						wr_addr_q <= q_entry.dst;
						remain_q  <= q_entry.len;
						state_q   <= ST_COPY;
					end else if (q_valid && q_ready && q_entry.op == lzwd_pkg::OP_END) begin
						sweep_q <= lzwd_pkg::FILL_START;
						state_q <= ST_FILL;
					end
				end
				ST_COPY: begin
					if (rd_en) begin
						rd_addr_q <= rd_addr_q + 1'b1;
						wr_addr_q <= wr_addr_q + 1'b1;
						remain_q  <= remain_q - 1'b1;
						if (remain_q == lzwd_pkg::LEN_W'(1)) begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign out_byte  = out_byte_q;
	assign last      = last_q;

endmodule

// ===== rtl/lzss_window_decoder.sv =====
`timescale 1ns / 1ps
// Channel  Direction  Handshake            Beat contents
// in       input      in_valid / in_ready  command, literal_byte, length_code, distance
// out      output     out_valid / out_ready out_byte, last
//
// A literal writes one window byte; a copy of n bytes does one window read and one
// write per byte through the byte memory (one read port, one write port), and an
// end of stream refills the top 60 window entries with spaces.
// After reset a clearing pass writes all 8192 window entries, one a cycle; in_ready
// stays low while that pass runs. A two-entry queue sits between classification and
// execution, and the output register lets the window work go on for one more byte
// while out_ready is low.

module lzss_window_decoder (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [1:0]                    command,
	input  logic [7:0]                    literal_byte,
	input  logic [lzwd_pkg::LCODE_W-1:0]  length_code,
	input  logic [lzwd_pkg::WIN_AW-1:0]   distance,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [7:0]                    out_byte,
	output logic                          last
);

	logic             init_busy;
	logic             push_valid;
	logic             push_ready;
	lzwd_pkg::entry_t push_entry;
	logic             pop_valid;
	logic             pop_ready;
	lzwd_pkg::entry_t pop_entry;

	lzwd_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.command      (command),
		.literal_byte (literal_byte),
		.length_code  (length_code),
		.distance     (distance),
		.init_busy    (init_busy),
		.push_valid   (push_valid),
		.push_ready   (push_ready),
		.push_entry   (push_entry)
	);

	lzwd_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_entry (push_entry),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_entry  (pop_entry)
	);

	lzwd_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (pop_valid),
		.q_ready   (pop_ready),
		.q_entry   (pop_entry),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_byte  (out_byte),
		.last      (last),
		.init_busy (init_busy)
	);

endmodule

// ===== rtl/lzwd_checker.sv =====
`timescale 1ns / 1ps
`include "lzss_window_decoder_assert.svh"

module lzwd_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_ready,
	input logic [1:0] command,
	input logic       out_valid,
	input logic       out_ready,
	input logic [7:0] out_byte,
	input logic       last
);

	// Items in flight that still owe a final beat. At most two in the queue, one
	// being copied, one in stage 2 and one in the output register.
	logic [2:0] pending_q;
	logic       item_in;
	logic       item_out;

	assign item_in  = in_valid && in_ready &&
		(command == lzwd_pkg::CMD_LITERAL || command == lzwd_pkg::CMD_COPY);
	assign item_out = out_valid && out_ready && last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= '0;
		end else if (item_in && !item_out) begin
			pending_q <= pending_q + 1'b1;
		end else if (item_out && !item_in) begin
			pending_q <= pending_q - 1'b1;
		end
	end

	`LZWD_ASSERT_NEXT(a_out_valid_hold, out_valid && !out_ready, out_valid, "out beat dropped")
	`LZWD_ASSERT_NEXT(a_out_data_hold, out_valid && !out_ready, $stable(out_byte) && $stable(last), "stalled out beat changed")
	`LZWD_ASSERT_IMPL(a_no_spurious_out, out_valid, pending_q != 3'd0, "out beat with no item owed")
	`LZWD_ASSERT_IMPL(a_pending_bound, 1'b1, pending_q <= 3'd5, "too many items in flight")

endmodule

bind lzss_window_decoder lzwd_checker u_lzwd_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.command   (command),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.out_byte  (out_byte),
	.last      (last)
);
